// File: sv/pidaw_pkg.sv
// shared constants, register codes and saturation helper for the pid controller
`default_nettype none
package pidaw_pkg;

	localparam int CHANNELS  = 2;
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int GAIN_W    = 24;
	localparam int LIMIT_W   = 31;
	localparam int MASK_W    = 2;
	localparam int SIG_W     = 32;
	localparam int PROD_W    = GAIN_W + 1 + SIG_W + 1;
	localparam int FRAC_W    = 16;
	localparam int SHIFT_W   = PROD_W - FRAC_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_OUTPUT_LIMIT   = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_INVERT_MASK    = 3'd5
	} cfg_reg_t;

	// saturate a signed value to signed 32 bits
	function automatic logic signed [SIG_W-1:0] sat_to_32(input logic signed [SHIFT_W-1:0] x);
		logic signed [SIG_W-1:0] r;
		if ((&x[SHIFT_W-1:SIG_W-1]) || !(|x[SHIFT_W-1:SIG_W-1])) begin
			r = x[SIG_W-1:0];
		end else if (x[SHIFT_W-1]) begin
			r = {1'b1, {(SIG_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SIG_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: sv/pidaw_if.sv
// valid/ready channel interfaces for input items, result items and register writes
`default_nettype none
interface pidaw_in_if import pidaw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    channel;
	logic signed [SIG_W-1:0] setpoint;
	logic signed [SIG_W-1:0] measured;

	modport source (output valid, output channel, output setpoint, output measured, input ready);
	modport sink (input valid, input channel, input setpoint, input measured, output ready);
endinterface

interface pidaw_out_if import pidaw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SIG_W-1:0] drive;
	logic                    saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink (input valid, input drive, input saturated, output ready);
endinterface

interface pidaw_cfg_if import pidaw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/pidaw_gain_mul.sv
// gain times operand, arithmetic shift by the fraction width, saturate to 32 bits
`default_nettype none
module pidaw_gain_mul import pidaw_pkg::*; (
	input  logic        [GAIN_W-1:0] gain,
	input  logic signed [SIG_W:0]    operand,
	output logic signed [SIG_W-1:0]  term
);

	logic signed [PROD_W-1:0] prod;

	assign prod = $signed({1'b0, gain}) * operand;
	assign term = sat_to_32(prod[PROD_W-1:FRAC_W]);

endmodule
`default_nettype wire

// File: sv/pid_antiwindup_controller.sv
// pid controller with per-channel state and anti-windup clamping
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while the output is not stalled; the per-channel error and
// integral are read after the input register and rewritten when the result register loads
// reset: gains and limits clear, invert mask goes to one, all channel state clears
`default_nettype none
module pid_antiwindup_controller import pidaw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pidaw_in_if.sink    in_ch,
	pidaw_out_if.source out_ch,
	pidaw_cfg_if.sink   cfg
);

	logic [GAIN_W-1:0]  gain_p_q;
	logic [GAIN_W-1:0]  gain_i_q;
	logic [GAIN_W-1:0]  gain_d_q;
	logic [LIMIT_W-1:0] output_limit_q;
	logic [LIMIT_W-1:0] integral_limit_q;
	logic [MASK_W-1:0]  invert_mask_q;

	logic                    valid_s1;
	logic                    channel_s1;
	logic signed [SIG_W-1:0] setpoint_s1;
	logic signed [SIG_W-1:0] measured_s1;

	logic                    out_valid_q;
	logic signed [SIG_W-1:0] drive_q;
	logic                    saturated_q;

	logic signed [SIG_W-1:0] prev_err_q [CHANNELS];
	logic signed [SIG_W-1:0] integ_q [CHANNELS];

	logic                      advance;
	logic [CH_W-1:0]           ch_idx;
	logic                      inv;
	logic signed [SIG_W:0]     meas_x;
	logic signed [SIG_W+1:0]   err_wide;
	logic signed [SIG_W-1:0]   err;
	logic signed [SIG_W-1:0]   prev;
	logic signed [SIG_W-1:0]   integ;
	logic signed [SIG_W:0]     p_op;
	logic signed [SIG_W:0]     d_op;
	logic signed [SIG_W:0]     i_op;
	logic signed [SIG_W-1:0]   p_term;
	logic signed [SIG_W-1:0]   d_term;
	logic signed [SIG_W-1:0]   i_term;
	logic signed [SIG_W+1:0]   cv_wide;
	logic signed [SIG_W+1:0]   lim_o;
	logic signed [SIG_W+1:0]   neg_lim_o;
	logic signed [SIG_W-1:0]   drive_d;
	logic                      maxed;
	logic signed [SIG_W:0]     integ_sum;
	logic signed [SIG_W:0]     lim_i;
	logic signed [SIG_W:0]     neg_lim_i;
	logic signed [SIG_W-1:0]   integ_d;

	// handshakes
	assign advance      = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.drive = drive_q;
	assign out_ch.saturated = saturated_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			output_limit_q   <= '0;
			integral_limit_q <= '0;
			invert_mask_q    <= MASK_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_GAIN_P:         gain_p_q         <= cfg.data[GAIN_W-1:0];
				REG_GAIN_I:         gain_i_q         <= cfg.data[GAIN_W-1:0];
				REG_GAIN_D:         gain_d_q         <= cfg.data[GAIN_W-1:0];
				REG_OUTPUT_LIMIT:   output_limit_q   <= cfg.data[LIMIT_W-1:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg.data[LIMIT_W-1:0];
				REG_INVERT_MASK:    invert_mask_q    <= cfg.data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			channel_s1  <= in_ch.channel;
			setpoint_s1 <= in_ch.setpoint;
			measured_s1 <= in_ch.measured;
		end
	end

	// error and operands
	always_comb begin
		ch_idx   = CH_W'(channel_s1 % CHANNELS);
		inv      = invert_mask_q[ch_idx[0]];
		meas_x   = {measured_s1[SIG_W-1], measured_s1};
		if (inv) begin
			meas_x = -meas_x;
		end
		err_wide = {{2{setpoint_s1[SIG_W-1]}}, setpoint_s1} - {meas_x[SIG_W], meas_x};
		err      = sat_to_32({{(SHIFT_W-SIG_W-2){err_wide[SIG_W+1]}}, err_wide});
		prev     = prev_err_q[ch_idx];
		integ    = integ_q[ch_idx];
		p_op     = {err[SIG_W-1], err};
		d_op     = {err[SIG_W-1], err} - {prev[SIG_W-1], prev};
		i_op     = {err[SIG_W-1], err} + {integ[SIG_W-1], integ};
	end

	pidaw_gain_mul u_mul_p (.gain(gain_p_q), .operand(p_op), .term(p_term));
	pidaw_gain_mul u_mul_d (.gain(gain_d_q), .operand(d_op), .term(d_term));
	pidaw_gain_mul u_mul_i (.gain(gain_i_q), .operand(i_op), .term(i_term));

	// output clamp and integral update
	always_comb begin
		cv_wide   = {{2{p_term[SIG_W-1]}}, p_term} + {{2{d_term[SIG_W-1]}}, d_term}
			+ {{2{i_term[SIG_W-1]}}, i_term};
		lim_o     = {3'b000, output_limit_q};
		neg_lim_o = -lim_o;
		maxed     = 1'b0;
		drive_d   = cv_wide[SIG_W-1:0];
		if (cv_wide > lim_o) begin
			drive_d = lim_o[SIG_W-1:0];
			maxed   = 1'b1;
		end else if (cv_wide < neg_lim_o) begin
			drive_d = neg_lim_o[SIG_W-1:0];
			maxed   = 1'b1;
		end
		if (maxed) begin
			integ_sum = '0;
		end else begin
			integ_sum = {integ[SIG_W-1], integ} + {err[SIG_W-1], err};
		end
		lim_i     = {2'b00, integral_limit_q};
		neg_lim_i = -lim_i;
		integ_d   = integ_sum[SIG_W-1:0];
		if (integ_sum > lim_i) begin
			integ_d = lim_i[SIG_W-1:0];
		end else if (integ_sum < neg_lim_i) begin
			integ_d = neg_lim_i[SIG_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_q     <= drive_d;
			saturated_q <= maxed;
		end
	end

	// per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				prev_err_q[c] <= '0;
				integ_q[c]    <= '0;
			end
		end else if (advance && valid_s1) begin
			prev_err_q[ch_idx] <= err;
			integ_q[ch_idx]    <= integ_d;
		end
	end

endmodule
`default_nettype wire
